@@ src/onu_pkg.sv @@
// ----------------------------------------------------------------------------
// onu_pkg - shared types and constants
// field widths, sequencer states and the control group for the scan unit
// ----------------------------------------------------------------------------
package onu_pkg;

  localparam int KEY_W = 64;
  localparam int NU_W  = 32;
  localparam int CAP_W = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_WRITE = 4'b1000
  } state_t;

  typedef struct packed {
    logic             clear;
    logic [KEY_W-1:0] key;
  } scan_ctrl_t;

endpackage

@@ src/optimal_next_use_replacement.sv @@
// ----------------------------------------------------------------------------
// optimal_next_use_replacement - fully associative cache, optimal replacement
// each access hits, fills a free slot or evicts the entry used furthest ahead
// ----------------------------------------------------------------------------
// sequencing: each filled slot is read from the entry store, one read per cycle, through the
//   shared compare, then the last read lands and the result is written back; an empty cache skips the scan
// access flow: one access at a time; a new access is taken only after the write back, which waits on out_stall
// reset: synchronous, clears the fill count, the sequencer and the output
//   valid, capacity returns to 64; stored entries are not cleared
module optimal_next_use_replacement #(
  parameter int ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [onu_pkg::CAP_W-1:0]     cfg_data,
  // access channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [onu_pkg::KEY_W-1:0]     key,
  input  logic [onu_pkg::NU_W-1:0]      next_use,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic                          evicted,
  output logic [onu_pkg::KEY_W-1:0]     evict_key
);

  // slot index and fill count widths
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int CW = (OW > onu_pkg::CAP_W) ? OW : onu_pkg::CAP_W;
  localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);
  localparam logic [OW-1:0] ENTRIES_O = OW'(ENTRIES);

  onu_pkg::state_t state, state_next;

  logic [onu_pkg::CAP_W-1:0] capacity;
  logic [OW-1:0]             occupancy;
  logic [IW-1:0]             cnt;
  logic [onu_pkg::KEY_W-1:0] key_q;
  logic [onu_pkg::NU_W-1:0]  nu_q;

  logic                      in_xfer;
  logic                      out_free;
  logic [CW-1:0]             cap_ext;
  logic [CW-1:0]             cap_eff;
  logic                      full;
  logic                      do_hit;
  logic                      do_evict;
  logic                      do_insert;
  logic                      commit;

  // store and compare unit wiring
  onu_pkg::scan_ctrl_t       scan_ctrl;
  logic                      mem_we;
  logic [IW-1:0]             mem_waddr;
  logic                      mem_re;
  logic                      rd_valid;
  logic [IW-1:0]             rd_idx;
  logic [onu_pkg::KEY_W+onu_pkg::NU_W-1:0] rd_data;
  logic                      match_found;
  logic [IW-1:0]             match_idx;
  logic [IW-1:0]             best_idx;
  logic [onu_pkg::KEY_W-1:0] best_key;

  assign in_stall = (state != onu_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // capacity of zero acts as one, anything above the store size saturates
  assign cap_ext = CW'(capacity);
  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > ENTRIES_C) begin
      cap_eff = ENTRIES_C;
    end else begin
      cap_eff = cap_ext;
    end
  end

  // entries are never freed, so valid slots are always 0 .. occupancy-1
  assign full      = (CW'(occupancy) >= cap_eff) || (occupancy == ENTRIES_O);
  assign do_hit    = match_found;
  assign do_evict  = !match_found && full;
  assign do_insert = !match_found && !full;
  assign commit    = (state == onu_pkg::ST_WRITE) && out_free;

  assign scan_ctrl.clear = in_xfer;
  assign scan_ctrl.key   = key_q;

  // one read per cycle while scanning
  assign mem_re = (state == onu_pkg::ST_SCAN);
  assign mem_we = commit;
  always_comb begin
    if (do_hit) begin
      mem_waddr = match_idx;
    end else if (do_evict) begin
      mem_waddr = best_idx;
    end else begin
      mem_waddr = occupancy[IW-1:0];
    end
  end

  onu_mem #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .we       (mem_we),
    .waddr    (mem_waddr),
    .wdata    ({key_q, nu_q}),
    .re       (mem_re),
    .raddr    (cnt),
    .rd_valid (rd_valid),
    .rd_idx   (rd_idx),
    .rd_data  (rd_data)
  );

  onu_scan #(
    .IW (IW)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (scan_ctrl),
    .rd_valid    (rd_valid),
    .rd_idx      (rd_idx),
    .rd_data     (rd_data),
    .match_found (match_found),
    .match_idx   (match_idx),
    .best_idx    (best_idx),
    .best_key    (best_key)
  );

  // sequencer: idle, scan the filled slots, let the last read land, write back
  always_comb begin
    state_next = state;
    case (state)
      onu_pkg::ST_IDLE: begin
        if (in_xfer) begin
          // an empty cache has nothing to look at
          state_next = (occupancy == '0) ? onu_pkg::ST_WRITE : onu_pkg::ST_SCAN;
        end
      end
      onu_pkg::ST_SCAN: begin
        if (OW'(cnt) + OW'(1) == occupancy) begin
          state_next = onu_pkg::ST_FLUSH;
        end
      end
      onu_pkg::ST_FLUSH: begin
        state_next = onu_pkg::ST_WRITE;
      end
      onu_pkg::ST_WRITE: begin
        if (out_free) begin
          state_next = onu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = onu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= onu_pkg::ST_IDLE;
      capacity  <= onu_pkg::CAP_RESET;
      occupancy <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (in_xfer) begin
        cnt <= '0;
      end else if (state == onu_pkg::ST_SCAN) begin
        cnt <= cnt + IW'(1);
      end
      if (commit && do_insert) begin
        occupancy <= occupancy + OW'(1);
      end
      // result register frees as soon as the far side takes the transfer
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // access and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_q <= key;
      nu_q  <= next_use;
    end
    if (commit) begin
      hit       <= do_hit;
      evicted   <= do_evict;
      evict_key <= do_evict ? best_key : '0;
    end
  end

endmodule

@@ src/onu_mem.sv @@
// ----------------------------------------------------------------------------
// onu_mem - entry store
// one write port and one registered read port holding key and next use
// ----------------------------------------------------------------------------
module onu_mem #(
  parameter int ENTRIES = 64,
  parameter int IW      = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 we,
  input  logic [IW-1:0]                        waddr,
  input  logic [onu_pkg::KEY_W+onu_pkg::NU_W-1:0] wdata,
  input  logic                                 re,
  input  logic [IW-1:0]                        raddr,
  output logic                                 rd_valid,
  output logic [IW-1:0]                        rd_idx,
  output logic [onu_pkg::KEY_W+onu_pkg::NU_W-1:0] rd_data
);

  logic [onu_pkg::KEY_W+onu_pkg::NU_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
      rd_idx  <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= re;
    end
  end

endmodule

@@ src/onu_scan.sv @@
// ----------------------------------------------------------------------------
// onu_scan - shared compare unit
// checks one stored entry per cycle for a key match and the largest next use
// ----------------------------------------------------------------------------
module onu_scan #(
  parameter int IW = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  onu_pkg::scan_ctrl_t                  ctrl,
  input  logic                                 rd_valid,
  input  logic [IW-1:0]                        rd_idx,
  input  logic [onu_pkg::KEY_W+onu_pkg::NU_W-1:0] rd_data,
  output logic                                 match_found,
  output logic [IW-1:0]                        match_idx,
  output logic [IW-1:0]                        best_idx,
  output logic [onu_pkg::KEY_W-1:0]            best_key
);

  logic                       best_valid;
  logic [onu_pkg::NU_W-1:0]   best_nu;
  logic [onu_pkg::KEY_W-1:0]  ent_key;
  logic [onu_pkg::NU_W-1:0]   ent_nu;
  logic                       is_match;
  logic                       is_better;

  assign ent_key  = rd_data[onu_pkg::KEY_W+onu_pkg::NU_W-1:onu_pkg::NU_W];
  assign ent_nu   = rd_data[onu_pkg::NU_W-1:0];
  assign is_match = (ent_key == ctrl.key);
  // later next use wins, ties go to the larger key
  assign is_better = !best_valid || (ent_nu > best_nu) ||
                     ((ent_nu == best_nu) && (ent_key > best_key));

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      match_found <= 1'b0;
      best_valid  <= 1'b0;
    end else if (rd_valid) begin
      if (is_match) begin
        match_found <= 1'b1;
      end
      if (is_better) begin
        best_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      if (is_match) begin
        match_idx <= rd_idx;
      end
      if (is_better) begin
        best_idx <= rd_idx;
        best_key <= ent_key;
        best_nu  <= ent_nu;
      end
    end
  end

endmodule

@@ src/onu_checker.sv @@
// ----------------------------------------------------------------------------
// onu_checker - port level checks
// watches the access and result channels of the cache over time
// ----------------------------------------------------------------------------
module onu_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_we,
  input logic [onu_pkg::CAP_W-1:0]     cfg_data,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [onu_pkg::KEY_W-1:0]     key,
  input logic [onu_pkg::NU_W-1:0]      next_use,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          hit,
  input logic                          evicted,
  input logic [onu_pkg::KEY_W-1:0]     evict_key
);

  // the block works on one access at a time
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("access transfer not followed by stall");

  // a result held by the far side stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(evict_key) && $stable(evicted)))
    else $error("stalled result changed");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> !evicted)
    else $error("hit reported with eviction");

  // evicted key is zero without an eviction
  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !evicted) |-> (evict_key == '0))
    else $error("evicted key set without eviction");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind optimal_next_use_replacement onu_checker u_onu_checker (.*);
